@@ src/weighted_coefficient_quantizer_assert.svh @@
// Assertion macros for the quantizer module
`ifndef WEIGHTED_COEFFICIENT_QUANTIZER_ASSERT_SVH
`define WEIGHTED_COEFFICIENT_QUANTIZER_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define WCQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define WCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/wcq_pkg.sv @@
`default_nettype none
package wcq_pkg;
    localparam int BinCount   = 1024;
    localparam int BinW       = $clog2(BinCount);
    localparam int MaxQuality = 63;
    localparam int DivW       = 33;   // quotient bits produced
    localparam int NumW       = 49;   // |coefficient| << 7 plus divisor
    localparam int DenW       = 50;   // divisor << 1 width
    localparam int SideW      = 33;   // saturated flag above reconstructed value

    typedef enum logic [1:0] {
        t_OP_QUANT = 2'd0,
        t_OP_DEQUANT = 2'd1,
        t_OP_WRITE = 2'd2,
        t_OP_NONE = 2'd3
    } t_op;

    typedef struct packed {
        logic        neg;
        logic        quant;
        logic        zero;
        logic        divz;
    } t_ctl;

    function automatic logic [31:0] step_frac(input logic [1:0] r);
        logic [31:0] v;
        unique case (r)
            2'd0:    v = 32'd85899346;
            2'd1:    v = 32'd108226394;
            default: v = 32'd136356712;
        endcase
        return v;
    endfunction

    // step in Q16.16 from a clamped quality index
    function automatic logic [31:0] step_q16(input logic [5:0] q_in);
        logic [5:0]  q;
        logic [11:0] q43;
        logic [1:0]  r;
        logic [4:0]  i;
        logic [63:0] sh;
        q = (q_in > 6'(MaxQuality)) ? 6'(MaxQuality) : q_in;
        // q / 3 as (q * 43) >> 7, exact over the 6-bit range
        q43 = 12'(q) * 12'd43;
        i = q43[11:7];
        r = 2'(q - ({1'b0, i} + {i, 1'b0}));
        sh = {32'd0, step_frac(r)} << i;
        sh = sh + 64'h8000;
        return sh[47:16];
    endfunction
endpackage
`default_nettype wire

@@ src/wcq_ram.sv @@
`default_nettype none
module wcq_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ src/wcq_divider.sv @@
`default_nettype none
// Restoring divider, one quotient bit per stage: q = num / den
module wcq_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [wcq_pkg::NumW-1:0]      i_num,
    input  wire logic [wcq_pkg::DenW-1:0]      i_den,
    input  wire wcq_pkg::t_ctl                 i_ctl,
    input  wire logic [wcq_pkg::SideW-1:0]     i_side,
    output logic                               o_valid,
    output logic [wcq_pkg::DivW-1:0]           o_quot,
    output wcq_pkg::t_ctl                      o_ctl,
    output logic [wcq_pkg::SideW-1:0]          o_side
);
    localparam int N = wcq_pkg::DivW;
    localparam int D = wcq_pkg::DenW;
    localparam int W = wcq_pkg::NumW;
    localparam int S = wcq_pkg::SideW;

    logic                    r_vld  [N];
    logic [W-1:0]            r_rem  [N];
    logic [N-1:0]            r_quo  [N];
    logic [D-1:0]            r_den  [N];
    wcq_pkg::t_ctl           r_ctl  [N];
    logic [S-1:0]            r_side [N];

    // a quotient too large for N bits comes out as all ones
    for (genvar s = 0; s < N; s++) begin : g_stage
        localparam int Sh = N - 1 - s;
        logic           vld_in;
        logic [W-1:0]   rem_in;
        logic [N-1:0]   quo_in;
        logic [D-1:0]   den_in;
        wcq_pkg::t_ctl  ctl_in;
        logic [S-1:0]   side_in;
        logic [D+W-1:0] rem_ext;
        logic [D+W-1:0] den_sh;
        logic           fit;

        if (s == 0) begin : g_head
            assign vld_in  = i_valid;
            assign rem_in  = i_num;
            assign quo_in  = '0;
            assign den_in  = i_den;
            assign ctl_in  = i_ctl;
            assign side_in = i_side;
        end else begin : g_body
            assign vld_in  = r_vld[s-1];
            assign rem_in  = r_rem[s-1];
            assign quo_in  = r_quo[s-1];
            assign den_in  = r_den[s-1];
            assign ctl_in  = r_ctl[s-1];
            assign side_in = r_side[s-1];
        end

        assign rem_ext = {{D{1'b0}}, rem_in};
        assign den_sh  = {{W{1'b0}}, den_in} << Sh;
        assign fit     = rem_ext >= den_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= fit ? W'(rem_ext - den_sh) : rem_in;
                r_quo[s]  <= quo_in | (N'(fit) << Sh);
                r_den[s]  <= den_in;
                r_ctl[s]  <= ctl_in;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quot  = r_quo[N-1];
    assign o_ctl   = r_ctl[N-1];
    assign o_side  = r_side[N-1];
endmodule
`default_nettype wire

@@ src/weighted_coefficient_quantizer.sv @@
`default_nettype none
// Weighted quantizer / dequantizer for Q8.24 frequency coefficients.
// Input words on s_axis: opcode in tuser, the rest in tdata. Opcode 2 writes a
// Q2.14 weight for a bin into the weight memory and gives no output word;
// opcode 3 is dropped. Quantize and dequantize read the bin weight and give one
// output word each on m_axis (level_out, reconstructed, saturated).
// Configuration: i_cfg_we writes the 6-bit quality register; the user must write it
// only while idle (not enforced); the step register takes the new value next clock.
// Throughput: one word per cycle while m_axis_tready does not hold the pipeline.
// Results reach m_axis_tvalid through the weight memory read, two multiply stages,
// the 33-stage restoring divider and the output register, which quantize and
// dequantize words pass through in order.
// Reset clears the pipeline valids and quality; weight memory contents stay
// undefined until written.
// While an output word waits with m_axis_tready low, the whole pipeline holds
// and s_axis_tready drops; nothing in flight is lost.
module weighted_coefficient_quantizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // bin_index[9:0], coefficient[41:10], level_in[57:42], weight_value[73:58], pad
    input  wire logic [79:0] s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // level_out[15:0], reconstructed[47:16]
    output logic [47:0]      m_axis_tdata,
    // saturated[0]
    output logic             m_axis_tuser
);
    logic        en;
    logic        acc;
    logic [5:0]  r_quality;
    logic [31:0] r_step;

    logic [9:0]  in_bin;
    logic [31:0] in_coef;
    logic [15:0] in_lvl;
    logic [15:0] in_wv;
    assign in_bin  = s_axis_tdata[9:0];
    assign in_coef = s_axis_tdata[41:10];
    assign in_lvl  = s_axis_tdata[57:42];
    assign in_wv   = s_axis_tdata[73:58];

    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;
    assign acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quality <= '0;
        end else if (i_cfg_we) begin
            r_quality <= i_cfg_wdata;
        end
    end
    always_ff @(posedge i_clk) begin
        r_step <= wcq_pkg::step_q16(r_quality);
    end

    logic        is_wr;
    logic        is_op;
    logic [15:0] rd_w;
    assign is_wr = acc && (s_axis_tuser == wcq_pkg::t_OP_WRITE);
    assign is_op = acc && (s_axis_tuser == wcq_pkg::t_OP_QUANT
                           || s_axis_tuser == wcq_pkg::t_OP_DEQUANT);

    wcq_ram #(.Width(16), .Depth(wcq_pkg::BinCount)) u_ram (
        .i_clk   (i_clk),
        .i_we    (is_wr),
        .i_waddr (in_bin),
        .i_wdata (in_wv),
        .i_re    (en),
        .i_raddr (in_bin),
        .o_rdata (rd_w)
    );

    // stage 1: memory read; forward a same-bin write from the previous accepted word
    logic        r1_vld, r1_q, r1_fwd;
    logic [31:0] r1_coef;
    logic [15:0] r1_lvl, r1_fw;
    logic [9:0]  r_wbin;
    logic        r_wvld;
    logic [15:0] r_wdat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r_wvld <= 1'b0;
        end else if (en) begin
            r1_vld <= is_op;
            r_wvld <= is_wr;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_q    <= (s_axis_tuser == wcq_pkg::t_OP_QUANT);
            r1_coef <= in_coef;
            r1_lvl  <= in_lvl;
            r_wbin  <= in_bin;
            r_wdat  <= in_wv;
            r1_fwd  <= r_wvld && (r_wbin == in_bin);
            r1_fw   <= r_wdat;
        end
    end
    logic [15:0] w1;
    assign w1 = r1_fwd ? r1_fw : rd_w;

    // stage 2: divisor = step * weight
    logic        r2_vld, r2_q;
    logic [31:0] r2_coef;
    logic [15:0] r2_lvl;
    logic [47:0] r2_div;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_q    <= r1_q;
            r2_coef <= r1_coef;
            r2_lvl  <= r1_lvl;
            r2_div  <= r_step * w1;
        end
    end

    // stage 3: magnitudes, dequant product, divider operands
    logic        n_qneg, n_dneg;
    logic [31:0] n_qmag;
    logic [15:0] n_dmag;
    assign n_qneg = r2_coef[31];
    assign n_qmag = n_qneg ? 32'(-r2_coef) : r2_coef;
    assign n_dneg = r2_lvl[15];
    assign n_dmag = n_dneg ? 16'(-r2_lvl) : r2_lvl;

    logic          r3_vld;
    wcq_pkg::t_ctl r3_ctl;
    logic [wcq_pkg::NumW-1:0] r3_num;
    logic [wcq_pkg::DenW-1:0] r3_den;
    logic [63:0]   r3_prod;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ctl.quant <= r2_q;
            r3_ctl.neg   <= r2_q ? n_qneg : n_dneg;
            r3_ctl.zero  <= (n_qmag == 32'd0);
            r3_ctl.divz  <= (r2_div == 48'd0);
            r3_num       <= {10'd0, n_qmag, 7'd0} + {1'b0, r2_div};
            r3_den       <= {1'b0, r2_div, 1'b0};
            r3_prod      <= 64'(n_dmag) * 64'(r2_div);
        end
    end
    // round the dequant product to Q8.24 and clamp; it rides through the
    // divider beside the quotient
    logic [31:0] n_recon_r;
    logic        n_recon_sat;
    logic [63:0] n_rnd;
    assign n_rnd = (r3_prod + 64'd32) >> 6;
    always_comb begin
        n_recon_sat = 1'b0;
        n_recon_r   = n_rnd[31:0];
        if (!r3_ctl.neg && n_rnd > 64'h7FFF_FFFF) begin
            n_recon_r = 32'h7FFF_FFFF;
            n_recon_sat = 1'b1;
        end else if (r3_ctl.neg && n_rnd > 64'h8000_0000) begin
            n_recon_r = 32'h8000_0000;
            n_recon_sat = 1'b1;
        end
        if (r3_ctl.neg) begin
            n_recon_r = 32'(-n_recon_r);
        end
    end

    logic [wcq_pkg::SideW-1:0] side_in;
    assign side_in = {n_recon_sat, n_recon_r};

    logic          d_vld;
    logic [wcq_pkg::DivW-1:0] d_quo;
    wcq_pkg::t_ctl d_ctl;
    logic [wcq_pkg::SideW-1:0] d_side;

    wcq_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_vld),
        .i_num   (r3_num),
        .i_den   (r3_den),
        .i_ctl   (r3_ctl),
        .i_side  (side_in),
        .o_valid (d_vld),
        .o_quot  (d_quo),
        .o_ctl   (d_ctl),
        .o_side  (d_side)
    );

    // output stage: saturate the level, assemble the word
    logic [15:0] n_lvl;
    logic [31:0] n_rec;
    logic        n_sat;
    always_comb begin
        n_lvl = '0;
        n_rec = '0;
        n_sat = 1'b0;
        if (d_ctl.quant) begin
            if (d_ctl.zero) begin
                n_lvl = '0;
            end else if (d_ctl.divz) begin
                n_lvl = d_ctl.neg ? 16'h8000 : 16'h7FFF;
                n_sat = 1'b1;
            end else if (!d_ctl.neg && d_quo > 33'd32767) begin
                n_lvl = 16'h7FFF;
                n_sat = 1'b1;
            end else if (d_ctl.neg && d_quo > 33'd32768) begin
                n_lvl = 16'h8000;
                n_sat = 1'b1;
            end else begin
                n_lvl = d_ctl.neg ? 16'(-d_quo[15:0]) : d_quo[15:0];
            end
        end else begin
            n_rec = d_side[31:0];
            n_sat = d_side[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            m_axis_tvalid <= d_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata <= {n_rec, n_lvl};
            m_axis_tuser <= n_sat;
        end
    end

    `include "weighted_coefficient_quantizer_assert.svh"
    `WCQ_ASSERT_IMP(a_rdy_stall, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `WCQ_ASSERT_NEXT(a_wr_noout, i_clk, i_rst_n, is_wr, !r1_vld)
    `WCQ_ASSERT_IMP(a_zero_lvl, i_clk, i_rst_n,
        d_vld && d_ctl.quant && d_ctl.zero, n_lvl == 16'd0 && !n_sat)
endmodule
`default_nettype wire
